### rtl/gn2_pkg.sv
package gn2_pkg;

    // default configuration
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;

    // field widths
    localparam int COORD_W = 32;
    localparam int CELL_W  = 8;
    localparam int OUT_W   = 19;

    // output saturation bounds, signed q3.16
    localparam int OUT_MAX = 262143;
    localparam int OUT_MIN = -262144;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // gradient codes taken from the low two hash bits
    localparam logic [1:0] GRAD_POS_X = 2'd0;
    localparam logic [1:0] GRAD_NEG_X = 2'd1;
    localparam logic [1:0] GRAD_POS_Y = 2'd2;
    localparam logic [1:0] GRAD_NEG_Y = 2'd3;

    // register stages in the blend unit, gradients in to noise out
    localparam int BLEND_LAT = 8;

    // write port of one permutation table copy
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_perm_wr;

endpackage

### rtl/gradient_noise_2d.sv
// 2d gradient noise, one transaction per clock. A load transaction (kind 0) writes one
// permutation table entry; a sample transaction (kind 1) returns one signed q3.16 noise
// value, loads return nothing. The block is a 12-stage pipeline: with no back-pressure
// a new transaction is accepted every cycle. o_ready is high whenever the output register
// is empty or is being taken in the same cycle, so back-pressure freezes the whole
// pipeline and nothing is dropped or repeated. The table is held in three copies, each
// with one write and two read ports: the first resolves the x cell, the other two hash
// the four corners. A load reaches each copy in pipeline order, so every sample sees
// exactly the loads accepted before it. Table contents are undefined after reset; every
// entry a sample can reach must be loaded first. There is no clearing pass.
module gradient_noise_2d #(
    parameter int TABLE_DEPTH = gn2_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = gn2_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_kind,
    input  logic [gn2_pkg::CELL_W-1:0]           i_table_index,
    input  logic [gn2_pkg::CELL_W-1:0]           i_table_value,
    input  logic signed [gn2_pkg::COORD_W-1:0]   i_x_coord,
    input  logic signed [gn2_pkg::COORD_W-1:0]   i_y_coord,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [gn2_pkg::OUT_W-1:0]     o_noise_value
);
    import gn2_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int G_W   = F + 2;
    localparam int ONE   = 1 << F;
    localparam int VLD_N = BLEND_LAT + 2;

    function automatic logic signed [G_W-1:0] grad(
        input logic [1:0]            h,
        input logic signed [G_W-1:0] dx,
        input logic signed [G_W-1:0] dy
    );
        logic signed [G_W-1:0] g;
        case (h)
            GRAD_POS_X: g = dx;
            GRAD_NEG_X: g = -dx;
            GRAD_POS_Y: g = dy;
            GRAD_NEG_Y: g = -dy;
        endcase
        return g;
    endfunction

    logic w_adv;

    // stage 1: accepted transaction
    logic              r_s1_vld;
    logic              r_s1_kind;
    logic [CELL_W-1:0] r_s1_idx;
    logic [CELL_W-1:0] r_s1_val;
    logic [CELL_W-1:0] r_s1_cx;
    logic [CELL_W-1:0] r_s1_cy;
    logic [F-1:0]      r_s1_fx;
    logic [F-1:0]      r_s1_fy;
    // stage 2: x cell hash read back
    logic              r_s2_vld;
    logic              r_s2_kind;
    logic [CELL_W-1:0] r_s2_idx;
    logic [CELL_W-1:0] r_s2_val;
    logic [CELL_W-1:0] r_s2_cy;
    logic [F-1:0]      r_s2_fx;
    logic [F-1:0]      r_s2_fy;
    // stage 3: corner hashes read back
    logic [F-1:0]      r_s3_fx;
    logic [F-1:0]      r_s3_fy;
    // stage 4: corner gradients
    logic signed [G_W-1:0] r_g00, r_g10, r_g01, r_g11;
    // sample valid bits, stage 3 up to the output register
    logic [VLD_N-1:0]  r_smp_vld;

    t_perm_wr          w_wr_a, w_wr_bc;
    logic [CELL_W-1:0] w_pa0, w_pa1;
    logic [CELL_W-1:0] w_ha, w_hb;
    logic [CELL_W-1:0] w_h00, w_h01, w_h10, w_h11;
    logic signed [G_W-1:0] w_dx0, w_dx1, w_dy0, w_dy1;
    logic [F-1:0]      w_u, w_v;

    // whole pipeline moves when the output register is free
    assign w_adv   = !r_smp_vld[VLD_N-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_smp_vld[VLD_N-1];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_smp_vld <= '0;
        end else if (w_adv) begin
            r_s1_vld  <= i_valid;
            r_s2_vld  <= r_s1_vld;
            r_smp_vld <= {r_smp_vld[VLD_N-2:0], r_s2_vld && (r_s2_kind == KIND_SAMPLE)};
        end
    end

    // split coordinates into cell and fraction, carry the payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_kind <= i_kind;
            r_s1_idx  <= i_table_index;
            r_s1_val  <= i_table_value;
            r_s1_cx   <= i_x_coord[F+CELL_W-1:F];
            r_s1_cy   <= i_y_coord[F+CELL_W-1:F];
            r_s1_fx   <= i_x_coord[F-1:0];
            r_s1_fy   <= i_y_coord[F-1:0];

            r_s2_kind <= r_s1_kind;
            r_s2_idx  <= r_s1_idx;
            r_s2_val  <= r_s1_val;
            r_s2_cy   <= r_s1_cy;
            r_s2_fx   <= r_s1_fx;
            r_s2_fy   <= r_s1_fy;

            r_s3_fx   <= r_s2_fx;
            r_s3_fy   <= r_s2_fy;

            r_g00     <= grad(w_h00[1:0], w_dx0, w_dy0);
            r_g10     <= grad(w_h10[1:0], w_dx1, w_dy0);
            r_g01     <= grad(w_h01[1:0], w_dx0, w_dy1);
            r_g11     <= grad(w_h11[1:0], w_dx1, w_dy1);
        end
    end

    // table writes follow the load through the pipeline
    always_comb begin
        w_wr_a.en    = w_adv && r_s1_vld && (r_s1_kind == KIND_LOAD);
        w_wr_a.addr  = r_s1_idx;
        w_wr_a.data  = r_s1_val;
        w_wr_bc.en   = w_adv && r_s2_vld && (r_s2_kind == KIND_LOAD);
        w_wr_bc.addr = r_s2_idx;
        w_wr_bc.data = r_s2_val;
    end

    // x cell lookups
    gn2_perm_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram_a (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_wr       (w_wr_a),
        .i_rd_addr0 (r_s1_cx),
        .i_rd_addr1 (r_s1_cx + CELL_W'(1)),
        .o_rd_data0 (w_pa0),
        .o_rd_data1 (w_pa1)
    );

    assign w_ha = w_pa0 + r_s2_cy;
    assign w_hb = w_pa1 + r_s2_cy;

    // left corner hashes
    gn2_perm_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram_b (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_wr       (w_wr_bc),
        .i_rd_addr0 (w_ha),
        .i_rd_addr1 (w_ha + CELL_W'(1)),
        .o_rd_data0 (w_h00),
        .o_rd_data1 (w_h01)
    );

    // right corner hashes
    gn2_perm_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram_c (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_wr       (w_wr_bc),
        .i_rd_addr0 (w_hb),
        .i_rd_addr1 (w_hb + CELL_W'(1)),
        .o_rd_data0 (w_h10),
        .o_rd_data1 (w_h11)
    );

    // corner offsets: fraction and fraction minus one
    always_comb begin
        w_dx0 = signed'(G_W'(r_s3_fx));
        w_dy0 = signed'(G_W'(r_s3_fy));
        w_dx1 = w_dx0 - G_W'(ONE);
        w_dy1 = w_dy0 - G_W'(ONE);
    end

    // fade weights, ready at stage 4 next to the gradients
    gn2_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_t    (r_s1_fx),
        .o_fade (w_u)
    );

    gn2_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_t    (r_s1_fy),
        .o_fade (w_v)
    );

    // bilinear blend, scale and output register
    gn2_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_g00   (r_g00),
        .i_g10   (r_g10),
        .i_g01   (r_g01),
        .i_g11   (r_g11),
        .i_u     (w_u),
        .i_v     (w_v),
        .o_noise (o_noise_value)
    );

endmodule

### rtl/gn2_perm_ram.sv
module gn2_perm_ram #(
    parameter int TABLE_DEPTH = gn2_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  gn2_pkg::t_perm_wr           i_wr,
    input  logic [gn2_pkg::CELL_W-1:0]  i_rd_addr0,
    input  logic [gn2_pkg::CELL_W-1:0]  i_rd_addr1,
    output logic [gn2_pkg::CELL_W-1:0]  o_rd_data0,
    output logic [gn2_pkg::CELL_W-1:0]  o_rd_data1
);
    import gn2_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CELLS    = 1 << CELL_W;
    localparam int RECIP_SH = 16;
    localparam int RECIP    = (1 << RECIP_SH) / TABLE_DEPTH;
    localparam int PROD_W   = CELL_W + RECIP_SH;
    localparam int RM_W     = CELL_W + $clog2(TABLE_DEPTH + 1);

    // 8-bit index mod depth: reciprocal estimate, then one correction step
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [CELL_W-1:0] v);
        logic [PROD_W-1:0] prod;
        logic [CELL_W-1:0] q;
        logic [RM_W-1:0]   qd;
        logic [RM_W-1:0]   rem;
        prod = PROD_W'(v) * PROD_W'(RECIP);
        q    = prod[PROD_W-1:RECIP_SH];
        qd   = RM_W'(q) * RM_W'(TABLE_DEPTH);
        rem  = RM_W'(v) - qd;
        if (rem >= RM_W'(TABLE_DEPTH)) begin
            rem = rem - RM_W'(TABLE_DEPTH);
        end
        if (TABLE_DEPTH >= CELLS) begin
            return IDX_W'(v);
        end
        return IDX_W'(rem);
    endfunction

    logic [CELL_W-1:0] r_mem [TABLE_DEPTH];
    logic [CELL_W-1:0] r_rd0;
    logic [CELL_W-1:0] r_rd1;

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wrap_idx(i_wr.addr)] <= i_wr.data;
        end
        if (i_en) begin
            r_rd0 <= r_mem[wrap_idx(i_rd_addr0)];
            r_rd1 <= r_mem[wrap_idx(i_rd_addr1)];
        end
    end

    assign o_rd_data0 = r_rd0;
    assign o_rd_data1 = r_rd1;

endmodule

### rtl/gn2_fade.sv
module gn2_fade #(
    parameter int FRAC_BITS = gn2_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_t,
    output logic [FRAC_BITS-1:0] o_fade
);
    import gn2_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int ONE = 1 << F;
    localparam int W5  = F + 5;
    localparam int IN_W = F + 4;
    localparam logic signed [W5-1:0] K6  = W5'(6);
    localparam logic signed [W5-1:0] K10 = W5'(10 * ONE);
    localparam logic signed [W5-1:0] K15 = W5'(15 * ONE);

    logic signed [W5-1:0]   w_ts;
    logic signed [W5-1:0]   w_lin;
    logic signed [2*W5-1:0] w_pi;
    logic [2*F-1:0]         w_tt;
    logic [2*F-1:0]         w_cb;
    logic [2*F+3:0]         w_fd;

    logic signed [W5-1:0] r_im;
    logic [F-1:0]         r_tt;
    logic [F-1:0]         r_t;
    logic [F-1:0]         r_cube;
    logic [IN_W-1:0]      r_inner;
    logic [F-1:0]         r_fade;

    // stage a: t*(6t - 15) and t*t
    always_comb begin
        w_ts  = signed'(W5'(i_t));
        w_lin = w_ts * K6 - K15;
        w_pi  = (2*W5)'(w_ts) * (2*W5)'(w_lin);
        w_tt  = (2*F)'(i_t) * (2*F)'(i_t);
    end

    // stage b: t^3 and the inner polynomial
    assign w_cb = (2*F)'(r_tt) * (2*F)'(r_t);

    // stage c: t^3 * (6t^2 - 15t + 10), always below one
    assign w_fd = (2*F+4)'(r_cube) * (2*F+4)'(r_inner);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_im    <= W5'(w_pi >>> F);
            r_tt    <= w_tt[2*F-1:F];
            r_t     <= i_t;
            r_cube  <= w_cb[2*F-1:F];
            r_inner <= IN_W'(r_im + K10);
            r_fade  <= w_fd[2*F-1:F];
        end
    end

    assign o_fade = r_fade;

endmodule

### rtl/gn2_blend.sv
module gn2_blend #(
    parameter int FRAC_BITS = gn2_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [FRAC_BITS+1:0]         i_g00,
    input  logic signed [FRAC_BITS+1:0]         i_g10,
    input  logic signed [FRAC_BITS+1:0]         i_g01,
    input  logic signed [FRAC_BITS+1:0]         i_g11,
    input  logic [FRAC_BITS-1:0]                i_u,
    input  logic [FRAC_BITS-1:0]                i_v,
    output logic signed [gn2_pkg::OUT_W-1:0]    o_noise
);
    import gn2_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int D_W   = F + 3;
    localparam int M_W   = F + 3;
    localparam int R_W   = F + 3;
    localparam int DN_W  = F + 4;
    localparam int MN_W  = F + 4;
    localparam int N_W   = F + 5;
    localparam int SC_W  = F + 3;
    localparam int S_W   = F + 6;
    localparam int SH_W  = S_W + 16;
    localparam int P0_W  = F + 1 + D_W;
    localparam int P1_W  = F + 1 + DN_W;
    localparam int PS_W  = N_W + SC_W;
    localparam int SCALE = (21 * (1 << FRAC_BITS) + 5) / 10;
    localparam int unsigned SH_R = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int unsigned SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [SC_W-1:0]  SC     = SC_W'(SCALE);
    localparam logic signed [SH_W-1:0]  SAT_HI = SH_W'(OUT_MAX);
    localparam logic signed [SH_W-1:0]  SAT_LO = SH_W'(OUT_MIN);

    // stage 5: corner differences along x
    logic signed [D_W-1:0]   r5_d0, r5_d1;
    logic signed [F+1:0]     r5_g00, r5_g01;
    logic [F-1:0]            r5_u, r5_v;
    // stage 6: u-weighted differences
    logic signed [P0_W-1:0]  w_p0, w_p1;
    logic signed [M_W-1:0]   r6_m0, r6_m1;
    logic signed [F+1:0]     r6_g00, r6_g01;
    logic [F-1:0]            r6_v;
    // stage 7: row results
    logic signed [R_W-1:0]   r7_r0, r7_r1;
    logic [F-1:0]            r7_v;
    // stage 8: difference along y
    logic signed [DN_W-1:0]  r8_dn;
    logic signed [R_W-1:0]   r8_r0;
    logic [F-1:0]            r8_v;
    // stage 9: v-weighted difference
    logic signed [P1_W-1:0]  w_pn;
    logic signed [MN_W-1:0]  r9_mn;
    logic signed [R_W-1:0]   r9_r0;
    // stage 10: raw noise
    logic signed [N_W-1:0]   r10_n;
    // stage 11: scaled noise
    logic signed [PS_W-1:0]  w_ps;
    logic signed [S_W-1:0]   r11_s;
    // stage 12: output format and saturation
    logic signed [SH_W-1:0]  w_sh;
    logic signed [OUT_W-1:0] n_out;
    logic signed [OUT_W-1:0] r12_out;

    assign w_p0 = P0_W'(signed'({1'b0, r5_u})) * P0_W'(r5_d0);
    assign w_p1 = P0_W'(signed'({1'b0, r5_u})) * P0_W'(r5_d1);
    assign w_pn = P1_W'(signed'({1'b0, r8_v})) * P1_W'(r8_dn);
    assign w_ps = PS_W'(r10_n) * PS_W'(SC);

    // align to 16 fraction bits and clamp to the output range
    always_comb begin
        w_sh = (SH_W'(r11_s) >>> SH_R) <<< SH_L;
        if (w_sh > SAT_HI) begin
            n_out = OUT_W'(OUT_MAX);
        end else if (w_sh < SAT_LO) begin
            n_out = OUT_W'(OUT_MIN);
        end else begin
            n_out = OUT_W'(w_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_d0   <= D_W'(i_g10) - D_W'(i_g00);
            r5_d1   <= D_W'(i_g11) - D_W'(i_g01);
            r5_g00  <= i_g00;
            r5_g01  <= i_g01;
            r5_u    <= i_u;
            r5_v    <= i_v;

            r6_m0   <= M_W'(w_p0 >>> F);
            r6_m1   <= M_W'(w_p1 >>> F);
            r6_g00  <= r5_g00;
            r6_g01  <= r5_g01;
            r6_v    <= r5_v;

            r7_r0   <= R_W'(r6_g00) + r6_m0;
            r7_r1   <= R_W'(r6_g01) + r6_m1;
            r7_v    <= r6_v;

            r8_dn   <= DN_W'(r7_r1) - DN_W'(r7_r0);
            r8_r0   <= r7_r0;
            r8_v    <= r7_v;

            r9_mn   <= MN_W'(w_pn >>> F);
            r9_r0   <= r8_r0;

            r10_n   <= N_W'(r9_r0) + N_W'(r9_mn);

            r11_s   <= S_W'(w_ps >>> F);

            r12_out <= n_out;
        end
    end

    assign o_noise = r12_out;

endmodule

### rtl/gn2_checker.sv
module gn2_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic signed [gn2_pkg::OUT_W-1:0] o_noise_value
);
    import gn2_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // a stalled result stalls intake, so no transaction is lost in flight
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while output stalled");

    // result transaction holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_noise_value))
        else $error("output payload changed while stalled");

endmodule

bind gradient_noise_2d gn2_checker u_gn2_checker (.*);
